[sv/owtr_pkg.sv]
// ----------------------------------------------------------------------------
// owtr_pkg
// Types, register map and constants shared by the one-wire temperature reader.
// ----------------------------------------------------------------------------
`default_nettype none

package owtr_pkg;

    localparam int unsigned TIMER_W = 20;
    localparam int unsigned APB_AW  = 5;
    localparam int unsigned APB_DW  = 32;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_RST_LOW  = 4'd1,
        PH_RST_WAIT = 4'd2,
        PH_RST_REC  = 4'd3,
        PH_WR_START = 4'd4,
        PH_WR_HOLD  = 4'd5,
        PH_CONV     = 4'd6,
        PH_RD_START = 4'd7,
        PH_RD_WAIT  = 4'd8,
        PH_RD_REC   = 4'd9
    } phase_t;

    typedef enum logic [2:0] {
        REG_RESET_LOW     = 3'd0,
        REG_PRESENCE      = 3'd1,
        REG_RESET_REC     = 3'd2,
        REG_SLOT_START    = 3'd3,
        REG_WRITE_HOLD    = 3'd4,
        REG_READ_SAMPLE   = 3'd5,
        REG_READ_REC      = 3'd6,
        REG_CONV_WAIT     = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [9:0]  reset_low_us;
        logic [9:0]  presence_sample_us;
        logic [9:0]  reset_recovery_us;
        logic [5:0]  slot_start_us;
        logic [7:0]  write_hold_us;
        logic [5:0]  read_sample_us;
        logic [7:0]  read_recovery_us;
        logic [19:0] conversion_wait_us;
    } cfg_t;

    typedef struct packed {
        logic command;
        logic line_level;
    } in_t;

    typedef struct packed {
        logic               drive_low;
        logic               busy_res;
        logic               done_res;
        logic               status;
        logic signed [15:0] temperature_q4;
    } out_t;

    localparam logic [9:0]  RESET_LOW_RST     = 10'd480;
    localparam logic [9:0]  PRESENCE_RST      = 10'd70;
    localparam logic [9:0]  RESET_REC_RST     = 10'd410;
    localparam logic [5:0]  SLOT_START_RST    = 6'd2;
    localparam logic [7:0]  WRITE_HOLD_RST    = 8'd60;
    localparam logic [5:0]  READ_SAMPLE_RST   = 6'd10;
    localparam logic [7:0]  READ_REC_RST      = 8'd50;
    localparam logic [19:0] CONV_WAIT_RST     = 20'd800000;

    localparam logic [7:0] CMD_SKIP_ROM   = 8'hCC;
    localparam logic [7:0] CMD_CONVERT    = 8'h44;
    localparam logic [7:0] CMD_READ_SCRATCH = 8'hBE;

    localparam logic signed [15:0] NO_DEVICE_TEMP = 16'shF810;

    localparam logic [2:0] STEP_CONV      = 3'd2;
    localparam logic [2:0] STEP_READ      = 3'd4;
    localparam logic [2:0] STEP_LAST_READ = 3'd5;
    localparam logic [2:0] LAST_BIT       = 3'd7;

    function automatic logic [7:0] cmd_byte(input logic [1:0] step);
        logic [7:0] b;
        unique case (step)
            2'd0:    b = CMD_SKIP_ROM;
            2'd1:    b = CMD_CONVERT;
            2'd2:    b = CMD_SKIP_ROM;
            default: b = CMD_READ_SCRATCH;
        endcase
        return b;
    endfunction

    function automatic logic [TIMER_W-1:0] ticks_min1(input logic [TIMER_W-1:0] t);
        return (t == '0) ? TIMER_W'(1) : t;
    endfunction

endpackage

`default_nettype wire

[sv/owtr_regs.sv]
// ----------------------------------------------------------------------------
// owtr_regs
// APB register file holding the bus timing settings of the reader.
// ----------------------------------------------------------------------------
`default_nettype none

module owtr_regs (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [owtr_pkg::APB_AW-1:0]  paddr,
    input  wire logic [owtr_pkg::APB_DW-1:0]  pwdata,
    output logic      [owtr_pkg::APB_DW-1:0]  prdata,
    output logic                              pready,
    output owtr_pkg::cfg_t                    cfg
);

    owtr_pkg::cfg_t   cfg_reg;
    owtr_pkg::reg_idx_t idx;
    logic             wr_en;

    assign idx    = owtr_pkg::reg_idx_t'(paddr[owtr_pkg::APB_AW-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.reset_low_us       <= owtr_pkg::RESET_LOW_RST;
            cfg_reg.presence_sample_us <= owtr_pkg::PRESENCE_RST;
            cfg_reg.reset_recovery_us  <= owtr_pkg::RESET_REC_RST;
            cfg_reg.slot_start_us      <= owtr_pkg::SLOT_START_RST;
            cfg_reg.write_hold_us      <= owtr_pkg::WRITE_HOLD_RST;
            cfg_reg.read_sample_us     <= owtr_pkg::READ_SAMPLE_RST;
            cfg_reg.read_recovery_us   <= owtr_pkg::READ_REC_RST;
            cfg_reg.conversion_wait_us <= owtr_pkg::CONV_WAIT_RST;
        end else if (wr_en) begin
            unique case (idx)
                owtr_pkg::REG_RESET_LOW:   cfg_reg.reset_low_us       <= pwdata[9:0];
                owtr_pkg::REG_PRESENCE:    cfg_reg.presence_sample_us <= pwdata[9:0];
                owtr_pkg::REG_RESET_REC:   cfg_reg.reset_recovery_us  <= pwdata[9:0];
                owtr_pkg::REG_SLOT_START:  cfg_reg.slot_start_us      <= pwdata[5:0];
                owtr_pkg::REG_WRITE_HOLD:  cfg_reg.write_hold_us      <= pwdata[7:0];
                owtr_pkg::REG_READ_SAMPLE: cfg_reg.read_sample_us     <= pwdata[5:0];
                owtr_pkg::REG_READ_REC:    cfg_reg.read_recovery_us   <= pwdata[7:0];
                default:                   cfg_reg.conversion_wait_us <= pwdata[19:0];
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            owtr_pkg::REG_RESET_LOW:   prdata = 32'(cfg_reg.reset_low_us);
            owtr_pkg::REG_PRESENCE:    prdata = 32'(cfg_reg.presence_sample_us);
            owtr_pkg::REG_RESET_REC:   prdata = 32'(cfg_reg.reset_recovery_us);
            owtr_pkg::REG_SLOT_START:  prdata = 32'(cfg_reg.slot_start_us);
            owtr_pkg::REG_WRITE_HOLD:  prdata = 32'(cfg_reg.write_hold_us);
            owtr_pkg::REG_READ_SAMPLE: prdata = 32'(cfg_reg.read_sample_us);
            owtr_pkg::REG_READ_REC:    prdata = 32'(cfg_reg.read_recovery_us);
            default:                   prdata = 32'(cfg_reg.conversion_wait_us);
        endcase
    end

endmodule

`default_nettype wire

[sv/onewire_temperature_reader.sv]
// ----------------------------------------------------------------------------
// onewire_temperature_reader
// One-wire bus master that resets the bus, starts a conversion and reads
// back the signed raw temperature, one microsecond tick per request.
// ----------------------------------------------------------------------------
//   channel   ports                      carries
//   s_        s_valid s_ready s_data     one tick: command, line_level
//   m_        m_valid m_ready m_data     one result per tick: drive, flags, temp
//   apb       psel .. pready             eight timing registers at 4*index
//
// Each request is handled combinationally: the sequencer state and the request
// feed a single layer of logic whose result lands in the output register and
// is offered on the cycle after the request is taken.
// A new request is taken every cycle while the output register is empty or
// being drained; while a result waits, the next request waits with it.
// Reset leaves the sequencer idle and the timings at their default values.
// ----------------------------------------------------------------------------
`default_nettype none

module onewire_temperature_reader (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire owtr_pkg::in_t                s_data,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output owtr_pkg::out_t                    m_data,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [owtr_pkg::APB_AW-1:0]  paddr,
    input  wire logic [owtr_pkg::APB_DW-1:0]  pwdata,
    output logic      [owtr_pkg::APB_DW-1:0]  prdata,
    output logic                              pready
);

    localparam int unsigned TW = owtr_pkg::TIMER_W;

    owtr_pkg::cfg_t cfg;

    owtr_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    owtr_pkg::phase_t   phase_reg, phase_next, cur_phase;
    logic [TW-1:0]      timer_reg, timer_next, cur_timer;
    logic [2:0]         bit_reg, bit_next, cur_bit;
    logic [2:0]         byte_reg, byte_next, cur_byte, byte_inc;
    logic [7:0]         send_reg, send_next, cur_send;
    logic [15:0]        recv_reg, recv_next, cur_recv;
    logic signed [15:0] temp_reg, temp_next;
    logic               status_reg, status_next;
    logic               m_valid_reg;
    owtr_pkg::out_t     m_data_reg, result;
    logic               start, last, accept;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign start     = (phase_reg == owtr_pkg::PH_IDLE) && s_data.command;
    assign cur_phase = start ? owtr_pkg::PH_RST_LOW : phase_reg;
    assign cur_timer = start ? owtr_pkg::ticks_min1(TW'(cfg.reset_low_us)) : timer_reg;
    assign cur_bit   = start ? 3'd0 : bit_reg;
    assign cur_byte  = start ? 3'd0 : byte_reg;
    assign cur_send  = start ? 8'd0 : send_reg;
    assign cur_recv  = start ? 16'd0 : recv_reg;
    assign last      = (cur_timer[TW-1:1] == '0);
    assign byte_inc  = cur_byte + 3'd1;

    // Sequencer next state.
    always_comb begin
        phase_next  = cur_phase;
        timer_next  = (cur_phase != owtr_pkg::PH_IDLE && !last) ? cur_timer - TW'(1)
                                                                : cur_timer;
        bit_next    = cur_bit;
        byte_next   = cur_byte;
        send_next   = cur_send;
        recv_next   = cur_recv;
        temp_next   = temp_reg;
        status_next = status_reg;
        unique case (cur_phase)
            owtr_pkg::PH_RST_LOW: begin
                if (last) begin
                    phase_next = owtr_pkg::PH_RST_WAIT;
                    timer_next = owtr_pkg::ticks_min1(TW'(cfg.presence_sample_us));
                end
            end
            owtr_pkg::PH_RST_WAIT: begin
                if (last) begin
                    if (cur_byte == 3'd0 && s_data.line_level) begin
                        status_next = 1'b1;
                        temp_next   = owtr_pkg::NO_DEVICE_TEMP;
                        phase_next  = owtr_pkg::PH_IDLE;
                        timer_next  = '0;
                    end else begin
                        phase_next = owtr_pkg::PH_RST_REC;
                        timer_next = owtr_pkg::ticks_min1(TW'(cfg.reset_recovery_us));
                    end
                end
            end
            owtr_pkg::PH_RST_REC: begin
                if (last) begin
                    send_next  = owtr_pkg::cmd_byte(cur_byte[1:0]);
                    bit_next   = 3'd0;
                    phase_next = owtr_pkg::PH_WR_START;
                    timer_next = owtr_pkg::ticks_min1(TW'(cfg.slot_start_us));
                end
            end
            owtr_pkg::PH_WR_START: begin
                if (last) begin
                    phase_next = owtr_pkg::PH_WR_HOLD;
                    timer_next = owtr_pkg::ticks_min1(TW'(cfg.write_hold_us));
                end
            end
            owtr_pkg::PH_WR_HOLD: begin
                if (last) begin
                    send_next = {1'b0, cur_send[7:1]};
                    if (cur_bit == owtr_pkg::LAST_BIT) begin
                        bit_next  = 3'd0;
                        byte_next = byte_inc;
                        if (byte_inc == owtr_pkg::STEP_CONV) begin
                            phase_next = owtr_pkg::PH_CONV;
                            timer_next = owtr_pkg::ticks_min1(cfg.conversion_wait_us);
                        end else if (byte_inc >= owtr_pkg::STEP_READ) begin
                            phase_next = owtr_pkg::PH_RD_START;
                            timer_next = owtr_pkg::ticks_min1(TW'(cfg.slot_start_us));
                        end else begin
                            send_next  = owtr_pkg::cmd_byte(byte_inc[1:0]);
                            phase_next = owtr_pkg::PH_WR_START;
                            timer_next = owtr_pkg::ticks_min1(TW'(cfg.slot_start_us));
                        end
                    end else begin
                        bit_next   = cur_bit + 3'd1;
                        phase_next = owtr_pkg::PH_WR_START;
                        timer_next = owtr_pkg::ticks_min1(TW'(cfg.slot_start_us));
                    end
                end
            end
            owtr_pkg::PH_CONV: begin
                if (last) begin
                    phase_next = owtr_pkg::PH_RST_LOW;
                    timer_next = owtr_pkg::ticks_min1(TW'(cfg.reset_low_us));
                end
            end
            owtr_pkg::PH_RD_START: begin
                if (last) begin
                    phase_next = owtr_pkg::PH_RD_WAIT;
                    timer_next = owtr_pkg::ticks_min1(TW'(cfg.read_sample_us));
                end
            end
            owtr_pkg::PH_RD_WAIT: begin
                if (last) begin
                    recv_next  = {s_data.line_level, cur_recv[15:1]};
                    phase_next = owtr_pkg::PH_RD_REC;
                    timer_next = owtr_pkg::ticks_min1(TW'(cfg.read_recovery_us));
                end
            end
            owtr_pkg::PH_RD_REC: begin
                if (last) begin
                    phase_next = owtr_pkg::PH_RD_START;
                    timer_next = owtr_pkg::ticks_min1(TW'(cfg.slot_start_us));
                    if (cur_bit == owtr_pkg::LAST_BIT) begin
                        bit_next = 3'd0;
                        if (cur_byte >= owtr_pkg::STEP_LAST_READ) begin
                            status_next = 1'b0;
                            temp_next   = cur_recv;
                            phase_next  = owtr_pkg::PH_IDLE;
                            timer_next  = '0;
                            byte_next   = 3'd0;
                        end else begin
                            byte_next = byte_inc;
                        end
                    end else begin
                        bit_next = cur_bit + 3'd1;
                    end
                end
            end
            default: begin
                phase_next = owtr_pkg::PH_IDLE;
            end
        endcase
    end

    // Result of the current tick.
    always_comb begin
        result.busy_res       = (cur_phase != owtr_pkg::PH_IDLE);
        result.status         = status_next;
        result.temperature_q4 = temp_next;
        result.drive_low      = 1'b0;
        result.done_res       = 1'b0;
        unique case (cur_phase)
            owtr_pkg::PH_RST_LOW,
            owtr_pkg::PH_WR_START,
            owtr_pkg::PH_RD_START: begin
                result.drive_low = 1'b1;
            end
            owtr_pkg::PH_WR_HOLD: begin
                result.drive_low = !cur_send[0];
            end
            owtr_pkg::PH_RST_WAIT: begin
                result.done_res = last && (cur_byte == 3'd0) && s_data.line_level;
            end
            owtr_pkg::PH_RD_REC: begin
                result.done_res = last && (cur_bit == owtr_pkg::LAST_BIT)
                               && (cur_byte >= owtr_pkg::STEP_LAST_READ);
            end
            default: begin
                result.drive_low = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= owtr_pkg::PH_IDLE;
            timer_reg   <= '0;
            bit_reg     <= '0;
            byte_reg    <= '0;
            send_reg    <= '0;
            recv_reg    <= '0;
            temp_reg    <= '0;
            status_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg   <= phase_next;
                timer_reg   <= timer_next;
                bit_reg     <= bit_next;
                byte_reg    <= byte_next;
                send_reg    <= send_next;
                recv_reg    <= recv_next;
                temp_reg    <= temp_next;
                status_reg  <= status_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= result;
        end
    end

endmodule

`default_nettype wire
